// File: hw/rtl/tral_pkg.sv
`default_nettype none
package tral_pkg;
    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_BUDGET = 4'd1, ST_BAD_ID = 4'd2, ST_DUP = 4'd3,
        ST_QFULL = 4'd4, ST_WFULL = 4'd5, ST_CTRL = 4'd6, ST_PRIV = 4'd7,
        ST_MAPD = 4'd8, ST_SPILL = 4'd9, ST_CACHE = 4'd10, ST_OVF = 4'd11,
        ST_NOTFOUND = 4'd12, ST_STATE = 4'd13
    } status_t;

    typedef enum logic [2:0] {
        K_NONE = 3'd0, K_QUEUE = 3'd1, K_WORKER = 3'd2, K_PRIV = 3'd3,
        K_MAPD = 3'd4, K_SPILL = 3'd5, K_CACHE = 3'd6, K_CKPT = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        RQ_RESERVE = 3'd0, RQ_ACTIVATE = 3'd1, RQ_REQUEUE = 3'd2,
        RQ_REL_Q = 3'd3, RQ_REL_A = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_BYTES, S_DONE
    } fsm_t;

    localparam logic [2:0] RG_MAXQ = 3'd0;
    localparam logic [2:0] RG_MAXW = 3'd1;
    localparam logic [2:0] RG_RSVC = 3'd2;
    localparam logic [2:0] RG_CKPT = 3'd3;
    localparam logic [2:0] RG_LPRIV = 3'd4;
    localparam logic [2:0] RG_LMAPD = 3'd5;
    localparam logic [2:0] RG_LSPILL = 3'd6;
    localparam logic [2:0] RG_LCACHE = 3'd7;
endpackage
`default_nettype wire

// File: hw/rtl/tral_if.sv
`default_nettype none
interface tral_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] task_id;
    logic        is_control;
    logic [63:0] demand_private;
    logic [63:0] demand_mapped;
    logic [63:0] demand_spill;
    logic [63:0] demand_cache;
    modport source (output valid, req_type, task_id, is_control, demand_private,
        demand_mapped, demand_spill, demand_cache, input ready);
    modport sink (input valid, req_type, task_id, is_control, demand_private,
        demand_mapped, demand_spill, demand_cache, output ready);
endinterface

interface tral_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [2:0]  error_kind;
    logic [63:0] error_limit;
    logic [63:0] error_requested;
    logic [63:0] error_in_use;
    logic [6:0]  queued_count;
    logic [4:0]  active_count;
    logic [4:0]  active_control_count;
    logic [4:0]  active_plain_count;
    logic [4:0]  slots_free_control;
    logic [4:0]  slots_free_plain;
    modport source (output valid, status, error_kind, error_limit, error_requested,
        error_in_use, queued_count, active_count, active_control_count,
        active_plain_count, slots_free_control, slots_free_plain, input ready);
    modport sink (input valid, status, error_kind, error_limit, error_requested,
        error_in_use, queued_count, active_count, active_control_count,
        active_plain_count, slots_free_control, slots_free_plain, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/task_resource_admission_ledger.sv
// Task admission ledger.
// Requests arrive on req (valid/ready); each produces exactly one response on rsp.
// Configuration is written through the APB port (8-byte stride, 64-bit data),
// by the user only while the block is idle (the block does not enforce this).
// Reads return the register values. A request scans the reservation table
// one entry per cycle (the entry memory has a single, registered read port),
// goes through a decide state, checks the byte limits of a passing reserve
// one resource per cycle in S_BYTES, up to all four, and writes back in
// S_DONE. A new request is taken the cycle after the response transfer.
// The output register holds its response while the receiver stalls; the block
// accepts no new request until it is taken.
// Reset empties the table at once (valid bits in flip-flops) and zeroes all
// counters and byte totals; the entry payload memory is not cleared.
`default_nettype none
module task_resource_admission_ledger
    import tral_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 80,
    parameter int unsigned CHECKPOINT_MAX = 60000
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tral_req_if.sink         req,
    tral_rsp_if.source       rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic [31:0] task_id;
        logic        active;
        logic        control;
        logic [63:0] need_private;
        logic [63:0] need_mapped;
        logic [63:0] need_spill;
        logic [63:0] need_cache;
    } entry_t;

    // configuration
    logic [6:0]  max_queued_reg;
    logic [4:0]  max_workers_reg;
    logic [4:0]  reserved_control_reg;
    logic [15:0] checkpoint_ms_reg;
    logic [63:0] limit_reg [4];

    wire [2:0] cfg_idx = paddr[5:3];
    wire cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_queued_reg <= 7'd64;
            max_workers_reg <= 5'd16;
            reserved_control_reg <= 5'd1;
            checkpoint_ms_reg <= 16'd100;
            for (int r = 0; r < 4; r++)
            begin
                limit_reg[r] <= 64'd1073741824;
            end
        end
        else if (cfg_we && paddr[2:0] == 3'd0)
        begin
            case (cfg_idx)
                RG_MAXQ:   max_queued_reg <= pwdata[6:0];
                RG_MAXW:   max_workers_reg <= pwdata[4:0];
                RG_RSVC:   reserved_control_reg <= pwdata[4:0];
                RG_CKPT:   checkpoint_ms_reg <= pwdata[15:0];
                default:   limit_reg[cfg_idx[1:0]] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            RG_MAXQ: prdata = {57'd0, max_queued_reg};
            RG_MAXW: prdata = {59'd0, max_workers_reg};
            RG_RSVC: prdata = {59'd0, reserved_control_reg};
            RG_CKPT: prdata = {48'd0, checkpoint_ms_reg};
            default: prdata = limit_reg[cfg_idx[1:0]];
        endcase
    end

    // table memory and valid bits
    entry_t          mem [TABLE_DEPTH];
    entry_t          rd_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    entry_t          mem_wdata;
    logic [IW-1:0]   rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[rd_addr];
    end

    // request capture
    logic [2:0]  rq_type_reg;
    logic [31:0] rq_id_reg;
    logic        rq_ctrl_reg;
    logic [63:0] rq_dem_reg [4];

    fsm_t state_reg, state_next;
    logic [IW-1:0] scan_reg;          // address being read
    logic          rd_pend_reg;       // read data for rd_idx_reg is present
    logic [IW-1:0] rd_idx_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    entry_t        hit_ent_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic [1:0]    res_reg;

    logic [6:0] queued_reg;
    logic [4:0] active_reg, actc_reg, actp_reg;
    logic [63:0] used_reg [4];

    logic [3:0]  st_reg;
    logic [2:0]  kind_reg;
    logic [63:0] lim_o_reg, rq_o_reg, use_o_reg;
    logic        rsp_valid_reg;

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    wire accept = req.valid && req.ready;
    wire scan_done = rd_pend_reg && (rd_idx_reg == LAST);
    assign rd_addr = scan_reg;

    // budget check
    status_t bud_st;
    kind_t   bud_k;
    logic [63:0] bud_l, bud_r;
    always_comb
    begin
        bud_st = ST_BUDGET;
        bud_k = K_NONE;
        bud_l = 64'd1;
        bud_r = 64'd0;
        if (max_queued_reg == 7'd0)
            bud_k = K_QUEUE;
        else if (max_workers_reg == 5'd0)
            bud_k = K_WORKER;
        else if (reserved_control_reg == 5'd0 || reserved_control_reg > max_workers_reg)
        begin
            bud_k = K_WORKER;
            bud_l = {59'd0, max_workers_reg};
            bud_r = {59'd0, reserved_control_reg};
        end
        else if (checkpoint_ms_reg == 16'd0 || 32'(checkpoint_ms_reg) > CHECKPOINT_MAX)
        begin
            bud_k = K_CKPT;
            bud_l = 64'(CHECKPOINT_MAX);
            bud_r = {48'd0, checkpoint_ms_reg};
        end
        else if (limit_reg[0] == 64'd0) bud_k = K_PRIV;
        else if (limit_reg[1] == 64'd0) bud_k = K_MAPD;
        else if (limit_reg[2] == 64'd0) bud_k = K_SPILL;
        else if (limit_reg[3] == 64'd0) bud_k = K_CACHE;
        else bud_st = ST_OK;
    end

    wire [4:0] plain_lim = (reserved_control_reg <= max_workers_reg)
        ? (max_workers_reg - reserved_control_reg) : 5'd0;

    // byte check one resource per cycle in S_BYTES loop via res_reg
    wire [63:0] u_cur = used_reg[res_reg];
    wire [63:0] d_cur = rq_dem_reg[res_reg];
    wire [64:0] sum_cur = {1'b0, u_cur} + {1'b0, d_cur};
    wire byte_fail = sum_cur[64] || (sum_cur[63:0] > limit_reg[res_reg]);
    logic pass_reg;    // decision so far passes, in byte phase

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_SCAN;
            S_SCAN:   if (scan_done) state_next = S_DECIDE;
            S_DECIDE: state_next = S_BYTES;
            // a passing reserve stays in S_BYTES until all four pass or one fails
            S_BYTES:  if (!(pass_reg && res_reg != 2'd3 && !byte_fail)) state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
            queued_reg <= '0;
            active_reg <= '0;
            actc_reg <= '0;
            actp_reg <= '0;
            for (int r = 0; r < 4; r++)
            begin
                used_reg[r] <= '0;
            end
            scan_reg <= '0;
            rd_pend_reg <= 1'b0;
            rd_idx_reg <= '0;
            hit_reg <= 1'b0;
            hit_idx_reg <= '0;
            hit_ent_reg <= '0;
            free_reg <= 1'b0;
            free_idx_reg <= '0;
            res_reg <= '0;
            pass_reg <= 1'b0;
            st_reg <= ST_OK;
            kind_reg <= K_NONE;
            lim_o_reg <= '0;
            rq_o_reg <= '0;
            use_o_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        scan_reg <= '0;
                        rd_pend_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg != LAST || !rd_pend_reg)
                        rd_pend_reg <= 1'b1;
                    rd_idx_reg <= scan_reg;
                    if (scan_reg != LAST)
                        scan_reg <= scan_reg + IW'(1);
                    if (rd_pend_reg)
                    begin
                        if (valid_reg[rd_idx_reg] && rd_reg.task_id == rq_id_reg && !hit_reg)
                        begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                            hit_ent_reg <= rd_reg;
                        end
                        if (!valid_reg[rd_idx_reg] && !free_reg)
                        begin
                            free_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                    end
                end
                S_DECIDE:
                begin
                    st_reg <= ST_OK;
                    kind_reg <= K_NONE;
                    lim_o_reg <= '0;
                    rq_o_reg <= '0;
                    use_o_reg <= '0;
                    pass_reg <= 1'b0;
                    res_reg <= '0;
                    case (rq_type_reg)
                        RQ_RESERVE:
                        begin
                            if (bud_st != ST_OK)
                            begin
                                st_reg <= bud_st;
                                kind_reg <= bud_k;
                                lim_o_reg <= bud_l;
                                rq_o_reg <= bud_r;
                            end
                            else if (rq_id_reg == 32'd0)
                                st_reg <= ST_BAD_ID;
                            else if (hit_reg)
                                st_reg <= ST_DUP;
                            else if (queued_reg >= max_queued_reg || !free_reg)
                            begin
                                st_reg <= ST_QFULL;
                                kind_reg <= K_QUEUE;
                                lim_o_reg <= {57'd0, max_queued_reg};
                                rq_o_reg <= 64'd1;
                                use_o_reg <= {57'd0, queued_reg};
                            end
                            else
                                pass_reg <= 1'b1;
                        end
                        RQ_ACTIVATE:
                        begin
                            if (!hit_reg) st_reg <= ST_NOTFOUND;
                            else if (hit_ent_reg.active)
                            begin
                                st_reg <= ST_STATE;
                                kind_reg <= K_QUEUE;
                            end
                            else if (active_reg >= max_workers_reg)
                            begin
                                st_reg <= ST_WFULL;
                                kind_reg <= K_WORKER;
                                lim_o_reg <= {59'd0, max_workers_reg};
                                rq_o_reg <= 64'd1;
                                use_o_reg <= {59'd0, active_reg};
                            end
                            else if (!rq_ctrl_reg && actp_reg >= plain_lim)
                            begin
                                st_reg <= ST_CTRL;
                                kind_reg <= K_WORKER;
                                lim_o_reg <= {59'd0, plain_lim};
                                rq_o_reg <= 64'd1;
                                use_o_reg <= {59'd0, actp_reg};
                            end
                            else
                            begin
                                valid_reg[hit_idx_reg] <= 1'b1;
                                queued_reg <= queued_reg - 7'd1;
                                active_reg <= active_reg + 5'd1;
                                if (rq_ctrl_reg) actc_reg <= actc_reg + 5'd1;
                                else actp_reg <= actp_reg + 5'd1;
                            end
                        end
                        RQ_REQUEUE:
                        begin
                            if (!hit_reg) st_reg <= ST_NOTFOUND;
                            else if (!hit_ent_reg.active)
                            begin
                                st_reg <= ST_STATE;
                                kind_reg <= K_WORKER;
                            end
                            else if (queued_reg >= max_queued_reg)
                            begin
                                st_reg <= ST_QFULL;
                                kind_reg <= K_QUEUE;
                                lim_o_reg <= {57'd0, max_queued_reg};
                                rq_o_reg <= 64'd1;
                                use_o_reg <= {57'd0, queued_reg};
                            end
                            else
                            begin
                                if (hit_ent_reg.control) actc_reg <= actc_reg - 5'd1;
                                else actp_reg <= actp_reg - 5'd1;
                                active_reg <= active_reg - 5'd1;
                                queued_reg <= queued_reg + 7'd1;
                            end
                        end
                        RQ_REL_Q, RQ_REL_A:
                        begin
                            if (!hit_reg) st_reg <= ST_NOTFOUND;
                            else if (hit_ent_reg.active != (rq_type_reg == RQ_REL_A))
                            begin
                                st_reg <= ST_STATE;
                                kind_reg <= hit_ent_reg.active ? K_QUEUE : K_WORKER;
                            end
                            else
                            begin
                                if (rq_type_reg == RQ_REL_Q)
                                    queued_reg <= queued_reg - 7'd1;
                                else
                                begin
                                    active_reg <= active_reg - 5'd1;
                                    if (hit_ent_reg.control) actc_reg <= actc_reg - 5'd1;
                                    else actp_reg <= actp_reg - 5'd1;
                                end
                                used_reg[0] <= used_reg[0] - hit_ent_reg.need_private;
                                used_reg[1] <= used_reg[1] - hit_ent_reg.need_mapped;
                                used_reg[2] <= used_reg[2] - hit_ent_reg.need_spill;
                                used_reg[3] <= used_reg[3] - hit_ent_reg.need_cache;
                                valid_reg[hit_idx_reg] <= 1'b0;
                            end
                        end
                        default:
                            st_reg <= ST_STATE;
                    endcase
                end
                S_BYTES:
                begin
                    // four resources checked in sequence; stays here until done
                    if (pass_reg)
                    begin
                        if (byte_fail)
                        begin
                            pass_reg <= 1'b0;
                            st_reg <= sum_cur[64] ? ST_OVF : 4'(ST_PRIV + 4'(res_reg));
                            kind_reg <= 3'(K_PRIV + 3'(res_reg));
                            lim_o_reg <= limit_reg[res_reg];
                            rq_o_reg <= d_cur;
                            use_o_reg <= u_cur;
                        end
                        else if (res_reg != 2'd3)
                            res_reg <= res_reg + 2'd1;
                    end
                end
                S_DONE:
                begin
                    if (pass_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        for (int r = 0; r < 4; r++)
                        begin
                            used_reg[r] <= used_reg[r] + rq_dem_reg[r];
                        end
                        queued_reg <= queued_reg + 7'd1;
                    end
                    rsp_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rq_type_reg <= req.req_type;
            rq_id_reg <= req.task_id;
            rq_ctrl_reg <= req.is_control;
            rq_dem_reg[0] <= req.demand_private;
            rq_dem_reg[1] <= req.demand_mapped;
            rq_dem_reg[2] <= req.demand_spill;
            rq_dem_reg[3] <= req.demand_cache;
        end
    end

    // memory write: new entry on reserve, state change on activate/requeue
    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = hit_idx_reg;
        mem_wdata = hit_ent_reg;
        if (state_reg == S_DONE && pass_reg)
        begin
            mem_we = 1'b1;
            mem_waddr = free_idx_reg;
            mem_wdata.task_id = rq_id_reg;
            mem_wdata.active = 1'b0;
            mem_wdata.control = 1'b0;
            mem_wdata.need_private = rq_dem_reg[0];
            mem_wdata.need_mapped = rq_dem_reg[1];
            mem_wdata.need_spill = rq_dem_reg[2];
            mem_wdata.need_cache = rq_dem_reg[3];
        end
        else if (state_reg == S_DONE && st_reg == ST_OK && hit_reg &&
                 (rq_type_reg == RQ_ACTIVATE || rq_type_reg == RQ_REQUEUE))
        begin
            mem_we = 1'b1;
            mem_wdata.active = (rq_type_reg == RQ_ACTIVATE);
            mem_wdata.control = (rq_type_reg == RQ_ACTIVATE) && rq_ctrl_reg;
        end
    end

    wire [4:0] ctl_free = (active_reg <= max_workers_reg) ? max_workers_reg - active_reg : 5'd0;
    wire [4:0] quota = (actp_reg <= plain_lim) ? plain_lim - actp_reg : 5'd0;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.status = st_reg;
    assign rsp.error_kind = kind_reg;
    assign rsp.error_limit = lim_o_reg;
    assign rsp.error_requested = rq_o_reg;
    assign rsp.error_in_use = use_o_reg;
    assign rsp.queued_count = queued_reg;
    assign rsp.active_count = active_reg;
    assign rsp.active_control_count = actc_reg;
    assign rsp.active_plain_count = actp_reg;
    assign rsp.slots_free_control = ctl_free;
    assign rsp.slots_free_plain = (ctl_free < quota) ? ctl_free : quota;

    a_split: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == actc_reg + actp_reg)
        else $error("active split mismatch");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !req.ready)
        else $error("ready while response pending");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> rsp_valid_reg)
        else $error("response not raised");
endmodule
`default_nettype wire
